// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sbpd_pkg.sv
package sbpd_pkg;

  localparam int MaxHeight  = 512;
  localparam int StripWidth = 8;
  localparam int ColW       = $clog2(StripWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int HgtW       = 10;
  localparam int LenW       = 9;
  localparam int CntW       = 5;
  localparam int BufW       = 16;

  localparam logic [2:0] CFG_MODE       = 3'd0;
  localparam logic [2:0] CFG_TRANS_ON   = 3'd1;
  localparam logic [2:0] CFG_TRANS_COL  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT     = 3'd3;
  localparam logic [2:0] CFG_COLOUR_BIT = 3'd4;

  typedef enum logic [1:0] {
    PH_COLOUR = 2'd0,
    PH_BITS   = 2'd1,
    PH_DECODE = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_ONE    = 3'd1,
    ST_ONEONE = 3'd2,
    ST_LOAD   = 3'd3,
    ST_DELTA  = 3'd4,
    ST_RUN    = 3'd5
  } stage_e;

  typedef struct packed {
    logic hdr;
    logic load;
    logic pixel;
    logic decode;
    logic run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic colour_phase;
    logic done_phase;
    logic pending;
    logic need_ok;
    logic run_next;
    logic at_end;
    logic run_last;
    logic hold_v;
    logic slot_ok;
  } sts_t;

  typedef struct packed {
    logic            done;
    logic            we;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [LenW-1:0] len;
    logic [7:0]      colour;
  } result_t;

endpackage

// File: rtl/sbpd_datapath.sv
module sbpd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [9:0]            cfg_data_i,
  input  logic [7:0]            byte_i,
  input  sbpd_pkg::cmd_t        cmd_i,
  output sbpd_pkg::sts_t        sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_last_o,
  output sbpd_pkg::result_t     out_res_o
);

  logic                          mode_q, trans_on_q;
  logic [7:0]                    trans_col_q;
  logic [sbpd_pkg::HgtW-1:0]     height_q;
  logic [3:0]                    cbits_q;

  logic [sbpd_pkg::BufW-1:0]     buf_q, buf_d;
  logic [sbpd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [7:0]                    colour_q, colour_d;
  logic                          neg_q, neg_d;
  logic [sbpd_pkg::ColW-1:0]     col_q, col_d;
  logic [sbpd_pkg::RowW-1:0]     row_q, row_d;
  sbpd_pkg::phase_e              phase_q, phase_d;
  logic                          pend_q, pend_d;
  sbpd_pkg::stage_e              stage_q, stage_d;
  logic [sbpd_pkg::LenW-1:0]     rn_q, rn_d, rc_q, rc_d;
  logic [sbpd_pkg::ColW-1:0]     rcol_q, rcol_d;
  logic [sbpd_pkg::RowW-1:0]     rrow_q, rrow_d;
  sbpd_pkg::result_t             hold_q, hold_d, out_q, out_d;
  logic                          hold_v_q, hold_v_d, out_v_q, out_v_d, last_q, last_d;

  logic [sbpd_pkg::HgtW-1:0]     eff_h;
  logic [3:0]                    eff_b, need;
  logic [7:0]                    mask, v;
  logic                          at_end, we;
  logic [sbpd_pkg::ColW-1:0]     adv_col;
  logic [sbpd_pkg::RowW-1:0]     adv_row;
  logic [sbpd_pkg::LenW-1:0]     rc_inc;
  logic                          produce;
  sbpd_pkg::result_t             res;

  always_comb begin
    if (height_q == '0) begin
      eff_h = sbpd_pkg::HgtW'(1);
    end else if (height_q > sbpd_pkg::HgtW'(sbpd_pkg::MaxHeight)) begin
      eff_h = sbpd_pkg::HgtW'(sbpd_pkg::MaxHeight);
    end else begin
      eff_h = height_q;
    end
    if (cbits_q == 4'd0) begin
      eff_b = 4'd1;
    end else if (cbits_q > 4'd8) begin
      eff_b = 4'd8;
    end else begin
      eff_b = cbits_q;
    end
  end

  always_comb begin
    unique case (stage_q)
      sbpd_pkg::ST_LOAD:  need = eff_b;
      sbpd_pkg::ST_DELTA: need = 4'd3;
      sbpd_pkg::ST_RUN:   need = 4'd8;
      default:            need = 4'd1;
    endcase
  end

  assign mask   = 8'((9'd1 << need) - 9'd1);
  assign v      = buf_q[7:0] & mask;
  assign at_end = (col_q == sbpd_pkg::ColW'(sbpd_pkg::StripWidth - 1)) &&
                  ({1'b0, row_q} + sbpd_pkg::HgtW'(1) >= eff_h);
  assign we     = !(trans_on_q && (colour_q == trans_col_q));
  assign rc_inc = rc_q + sbpd_pkg::LenW'(1);

  // One pixel step in scan order of the current mode.
  always_comb begin
    adv_col = col_q;
    adv_row = row_q;
    if (!mode_q) begin
      if ({1'b0, row_q} + sbpd_pkg::HgtW'(1) >= eff_h) begin
        adv_row = '0;
        adv_col = col_q + sbpd_pkg::ColW'(1);
      end else begin
        adv_row = row_q + sbpd_pkg::RowW'(1);
      end
    end else begin
      if (col_q == sbpd_pkg::ColW'(sbpd_pkg::StripWidth - 1)) begin
        adv_col = '0;
        adv_row = row_q + sbpd_pkg::RowW'(1);
      end else begin
        adv_col = col_q + sbpd_pkg::ColW'(1);
      end
    end
  end

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    colour_d = colour_q;
    neg_d    = neg_q;
    col_d    = col_q;
    row_d    = row_q;
    phase_d  = phase_q;
    pend_d   = pend_q;
    stage_d  = stage_q;
    rn_d     = rn_q;
    rc_d     = rc_q;
    rcol_d   = rcol_q;
    rrow_d   = rrow_q;
    produce  = 1'b0;
    res      = '0;
    res.colour = colour_q;
    res.we     = we;

    if (cmd_i.hdr) begin
      buf_d    = '0;
      cnt_d    = '0;
      neg_d    = 1'b1;
      col_d    = '0;
      row_d    = '0;
      pend_d   = 1'b1;
      stage_d  = sbpd_pkg::ST_START;
      colour_d = byte_i;
      phase_d  = sbpd_pkg::PH_BITS;
    end

    if (cmd_i.load) begin
      if (phase_q == sbpd_pkg::PH_BITS) begin
        buf_d   = {8'd0, byte_i};
        cnt_d   = sbpd_pkg::CntW'(8);
        phase_d = sbpd_pkg::PH_DECODE;
      end else begin
        buf_d = buf_q | (sbpd_pkg::BufW'(byte_i) << cnt_q);
        cnt_d = cnt_q + sbpd_pkg::CntW'(8);
      end
    end

    if (cmd_i.pixel) begin
      produce  = 1'b1;
      res.len  = sbpd_pkg::LenW'(1);
      res.col  = col_q;
      res.row  = row_q;
      res.done = at_end;
      pend_d   = 1'b0;
      if (at_end) begin
        phase_d = sbpd_pkg::PH_DONE;
      end else begin
        col_d = adv_col;
        row_d = adv_row;
      end
    end

    if (cmd_i.decode) begin
      buf_d = buf_q >> need;
      cnt_d = cnt_q - sbpd_pkg::CntW'(need);
      unique case (stage_q)
        sbpd_pkg::ST_START: begin
          if (v == 8'd0) pend_d = 1'b1;
          else stage_d = sbpd_pkg::ST_ONE;
        end
        sbpd_pkg::ST_ONE: begin
          if (v == 8'd0) stage_d = sbpd_pkg::ST_LOAD;
          else if (!mode_q) stage_d = sbpd_pkg::ST_ONEONE;
          else stage_d = sbpd_pkg::ST_DELTA;
        end
        sbpd_pkg::ST_ONEONE: begin
          neg_d    = neg_q ^ v[0];
          colour_d = colour_q + ((neg_q ^ v[0]) ? 8'hFF : 8'd1);
          stage_d  = sbpd_pkg::ST_START;
          pend_d   = 1'b1;
        end
        sbpd_pkg::ST_LOAD: begin
          colour_d = v;
          if (!mode_q) neg_d = 1'b1;
          stage_d  = sbpd_pkg::ST_START;
          pend_d   = 1'b1;
        end
        sbpd_pkg::ST_DELTA: begin
          if (v == 8'd4) begin
            stage_d = sbpd_pkg::ST_RUN;
          end else begin
            colour_d = colour_q + v + 8'hFC;
            stage_d  = sbpd_pkg::ST_START;
            pend_d   = 1'b1;
          end
        end
        sbpd_pkg::ST_RUN: begin
          // Latch the run; the pixels are walked in the run state.
          stage_d = sbpd_pkg::ST_START;
          rn_d    = (v == 8'd0) ? sbpd_pkg::LenW'(256) : sbpd_pkg::LenW'(v);
          rc_d    = '0;
          rcol_d  = col_q;
          rrow_d  = row_q;
        end
        default: stage_d = sbpd_pkg::ST_START;
      endcase
    end

    if (cmd_i.run) begin
      rc_d = rc_inc;
      if (at_end) begin
        phase_d = sbpd_pkg::PH_DONE;
      end else begin
        col_d = adv_col;
        row_d = adv_row;
      end
      if (at_end || rc_inc == rn_q) begin
        produce  = 1'b1;
        res.len  = rc_inc;
        res.col  = rcol_q;
        res.row  = rrow_q;
        res.done = at_end;
      end
    end

    if (cmd_i.finish && phase_q == sbpd_pkg::PH_DONE) begin
      buf_d   = '0;
      cnt_d   = '0;
      stage_d = sbpd_pkg::ST_START;
    end
  end

  // Result staging: hold one result until it is known whether it is last.
  always_comb begin
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    last_d   = last_q;
    out_v_d  = out_v_q && !out_ready_i;
    if (produce) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        last_d  = 1'b0;
        out_v_d = 1'b1;
      end
      hold_d   = res;
      hold_v_d = 1'b1;
    end else if (cmd_i.finish && hold_v_q) begin
      out_d    = hold_q;
      last_d   = 1'b1;
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      trans_on_q  <= 1'b0;
      trans_col_q <= 8'd5;
      height_q    <= sbpd_pkg::HgtW'(480);
      cbits_q     <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbpd_pkg::CFG_MODE:       mode_q      <= cfg_data_i[0];
        sbpd_pkg::CFG_TRANS_ON:   trans_on_q  <= cfg_data_i[0];
        sbpd_pkg::CFG_TRANS_COL:  trans_col_q <= cfg_data_i[7:0];
        sbpd_pkg::CFG_HEIGHT:     height_q    <= cfg_data_i;
        sbpd_pkg::CFG_COLOUR_BIT: cbits_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      cnt_q    <= '0;
      colour_q <= '0;
      neg_q    <= 1'b1;
      col_q    <= '0;
      row_q    <= '0;
      phase_q  <= sbpd_pkg::PH_COLOUR;
      pend_q   <= 1'b1;
      stage_q  <= sbpd_pkg::ST_START;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      colour_q <= colour_d;
      neg_q    <= neg_d;
      col_q    <= col_d;
      row_q    <= row_d;
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      stage_q  <= stage_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rn_q   <= rn_d;
    rc_q   <= rc_d;
    rcol_q <= rcol_d;
    rrow_q <= rrow_d;
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign sts_o.colour_phase = (phase_q == sbpd_pkg::PH_COLOUR);
  assign sts_o.done_phase   = (phase_q == sbpd_pkg::PH_DONE);
  assign sts_o.pending      = pend_q;
  assign sts_o.need_ok      = (cnt_q >= sbpd_pkg::CntW'(need));
  assign sts_o.run_next     = (stage_q == sbpd_pkg::ST_RUN);
  assign sts_o.at_end       = at_end;
  assign sts_o.run_last     = at_end || (rc_inc == rn_q);
  assign sts_o.hold_v       = hold_v_q;
  assign sts_o.slot_ok      = !hold_v_q || !out_v_q || out_ready_i;

  assign out_valid_o = out_v_q;
  assign out_last_o  = last_q;
  assign out_res_o   = out_q;

endmodule

// File: rtl/sbpd_ctrl.sv
module sbpd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_start_i,
  output logic           in_ready_o,
  input  sbpd_pkg::sts_t sts_i,
  output sbpd_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_RUN  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_start_i || sts_i.colour_phase) begin
            cmd_o.hdr = 1'b1;
          end else if (!sts_i.done_phase) begin
            cmd_o.load = 1'b1;
            state_d    = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (sts_i.pending) begin
          if (sts_i.slot_ok) begin
            cmd_o.pixel = 1'b1;
            if (sts_i.at_end) state_d = S_FIN;
          end
        end else if (!sts_i.need_ok) begin
          state_d = S_FIN;
        end else begin
          cmd_o.decode = 1'b1;
          if (sts_i.run_next) state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.slot_ok) begin
          cmd_o.run = 1'b1;
          if (sts_i.at_end) state_d = S_FIN;
          else if (sts_i.run_last) state_d = S_STEP;
        end
      end
      S_FIN: begin
        if (sts_i.slot_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: rtl/strip_bitstream_pixel_decoder.sv
// Channel   Dir  Group                       Payload
// input     in   s_axis_tvalid/tready/tdata  tdata[7:0] data_byte, tuser strip_start
// result    out  m_axis_tvalid/tready/tdata  tdata[30:0] result fields, tlast last
// config    in   cfg_we_i/cfg_idx_i/cfg_data_i  register index and value
//
// Steps: a colour byte or an ignored byte is taken in the idle state. A stream
// byte is loaded, then each emitted pixel and each prefix bit or field decoded
// takes a step of its own, then the buffer is found short and a closing step
// ends the item. A run walks up to 256 pixels, one per cycle unless stalled.
// Reset: asynchronous, active low; run and result data registers are not reset.
// Stalls: one result is held back until the next one shows whether it is last;
// the decoder waits while hold stage and output register are full and tready is low.
`include "assert_macros.svh"

module strip_bitstream_pixel_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] strip_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_colour, [16:8] run_length, [19:17] start_column,
  // [28:20] start_row, [29] write_enable, [30] strip_done, [31] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last result of the input item
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);

  sbpd_pkg::cmd_t    cmd;
  sbpd_pkg::sts_t    sts;
  sbpd_pkg::result_t res;

  // Sequencer: walks pixels, codes and runs for each accepted item.
  sbpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_start_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Bit buffer, scan position, colour state and result staging.
  sbpd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.done, res.we, res.row, res.col, res.len, res.colour};

  // A new item is only taken once the previous one has flushed its last result.
  `ASSERT_IMPLIES(a_idle_hold_empty, clk_i, rst_ni, s_axis_tready, !sts.hold_v)
  // A result that ends the strip is always the last of its item.
  `ASSERT_IMPLIES(a_done_is_last, clk_i, rst_ni, m_axis_tvalid && res.done, m_axis_tlast)
  // Every result covers at least one pixel.
  `ASSERT_IMPLIES(a_len_nonzero, clk_i, rst_ni, m_axis_tvalid, res.len != '0)

endmodule

// File: verif/tb_strip_bitstream_pixel_decoder.sv
module tb_strip_bitstream_pixel_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded pixel or run as it leaves the block.
  typedef struct packed {
    logic       done;
    logic       we;
    logic [8:0] row;
    logic [2:0] col;
    logic [8:0] len;
    logic [7:0] colour;
    logic       last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  strip_bitstream_pixel_decoder dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers and the decoder state.
  logic       mode_q, trans_on_q;
  logic [7:0] trans_col_q;
  logic [9:0] height_q;
  logic [3:0] cbits_q;
  logic [15:0] buf_q;
  int          nbits_q;
  logic [7:0]  colour_q;
  logic        step_neg_q;
  int          col_q, row_q;
  sbpd_pkg::phase_e phase_q;
  logic        pend_q;
  sbpd_pkg::stage_e stage_q;

  pixel_t pixels_due[$];
  int     errors = 0;
  int     cycles = 0;
  bit     hold_off = 1'b0;

  function automatic int rows_eff();
    if (height_q == 0) return 1;
    if (height_q > sbpd_pkg::MaxHeight) return sbpd_pkg::MaxHeight;
    return height_q;
  endfunction

  function automatic int cbits_eff();
    if (cbits_q == 0) return 1;
    if (cbits_q > 8) return 8;
    return cbits_q;
  endfunction

  function automatic int pull_bits(int n);
    int v;
    v = buf_q & ((1 << n) - 1);
    buf_q = buf_q >> n;
    nbits_q -= n;
    return v;
  endfunction

  // Walk n pixels from the scan position, stopping at the strip end.
  task automatic emit_pixels(int n);
    pixel_t p;
    int     cnt;
    bit     fin;
    cnt = 0;
    fin = 0;
    p = '0;
    p.col = 3'(col_q);
    p.row = 9'(row_q);
    while (cnt < n && !fin) begin
      fin = (col_q == sbpd_pkg::StripWidth - 1) && (row_q + 1 >= rows_eff());
      cnt++;
      if (!fin) begin
        if (!mode_q) begin
          row_q++;
          if (row_q >= rows_eff()) begin
            row_q = 0;
            col_q = (col_q + 1) & 7;
          end
        end else begin
          col_q++;
          if (col_q >= sbpd_pkg::StripWidth) begin
            col_q = 0;
            row_q++;
          end
        end
      end
    end
    if (fin) phase_q = sbpd_pkg::PH_DONE;
    p.colour = colour_q;
    p.len = 9'(cnt);
    p.we = !(trans_on_q && colour_q == trans_col_q);
    p.done = fin;
    pixels_due.push_back(p);
  endtask

  // 0: needs bits, 1: code done (pixel due), 2: run emitted.
  task automatic run_codes(output int r);
    int need, v;
    forever begin
      case (stage_q)
        sbpd_pkg::ST_LOAD:  need = cbits_eff();
        sbpd_pkg::ST_DELTA: need = 3;
        sbpd_pkg::ST_RUN:   need = 8;
        default:            need = 1;
      endcase
      if (nbits_q < need) begin
        r = 0;
        return;
      end
      v = pull_bits(need);
      case (stage_q)
        sbpd_pkg::ST_START: begin
          if (v == 0) begin
            r = 1;
            return;
          end
          stage_q = sbpd_pkg::ST_ONE;
        end
        sbpd_pkg::ST_ONE: begin
          if (v == 0) stage_q = sbpd_pkg::ST_LOAD;
          else if (!mode_q) stage_q = sbpd_pkg::ST_ONEONE;
          else stage_q = sbpd_pkg::ST_DELTA;
        end
        sbpd_pkg::ST_ONEONE: begin
          if (v != 0) step_neg_q = !step_neg_q;
          colour_q = colour_q + (step_neg_q ? 8'hFF : 8'h01);
          stage_q = sbpd_pkg::ST_START;
          r = 1;
          return;
        end
        sbpd_pkg::ST_LOAD: begin
          colour_q = 8'(v);
          if (!mode_q) step_neg_q = 1'b1;
          stage_q = sbpd_pkg::ST_START;
          r = 1;
          return;
        end
        sbpd_pkg::ST_DELTA: begin
          if (v == 4) stage_q = sbpd_pkg::ST_RUN;
          else begin
            colour_q = 8'(colour_q + v + 8'hFC);
            stage_q = sbpd_pkg::ST_START;
            r = 1;
            return;
          end
        end
        default: begin
          stage_q = sbpd_pkg::ST_START;
          emit_pixels(v == 0 ? 256 : v);
          r = 2;
          return;
        end
      endcase
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic first);
    int due_prior, r;
    pixel_t p;
    if (first || phase_q == sbpd_pkg::PH_COLOUR) begin
      buf_q = 0;
      nbits_q = 0;
      step_neg_q = 1'b1;
      col_q = 0;
      row_q = 0;
      pend_q = 1'b1;
      stage_q = sbpd_pkg::ST_START;
      colour_q = b;
      phase_q = sbpd_pkg::PH_BITS;
      return;
    end
    if (phase_q == sbpd_pkg::PH_DONE) return;
    due_prior = pixels_due.size();
    if (phase_q == sbpd_pkg::PH_BITS) begin
      buf_q = 16'(b);
      nbits_q = 8;
      phase_q = sbpd_pkg::PH_DECODE;
    end else begin
      buf_q = buf_q | (16'(b) << nbits_q);
      nbits_q += 8;
    end
    forever begin
      if (pend_q) begin
        emit_pixels(1);
        pend_q = 1'b0;
        if (phase_q == sbpd_pkg::PH_DONE) break;
      end
      run_codes(r);
      if (r == 0) break;
      if (r == 1) pend_q = 1'b1;
      if (phase_q == sbpd_pkg::PH_DONE) break;
    end
    if (phase_q == sbpd_pkg::PH_DONE) begin
      buf_q = 0;
      nbits_q = 0;
      stage_q = sbpd_pkg::ST_START;
    end
    if (pixels_due.size() > due_prior) begin
      p = pixels_due.pop_back();
      p.last = 1'b1;
      pixels_due.push_back(p);
    end
  endtask

  // Send one item; gaps come in bursts so idling lands on every phase.
  int burst_left = 0;
  task automatic send_byte(logic [7:0] b, logic first);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, first);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      sbpd_pkg::CFG_MODE:       mode_q = val[0];
      sbpd_pkg::CFG_TRANS_ON:   trans_on_q = val[0];
      sbpd_pkg::CFG_TRANS_COL:  trans_col_q = val[7:0];
      sbpd_pkg::CFG_HEIGHT:     height_q = val;
      sbpd_pkg::CFG_COLOUR_BIT: cbits_q = val[3:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic m, logic ton, logic [7:0] tc, logic [9:0] h, logic [3:0] cb);
    wait_idle();
    write_reg(sbpd_pkg::CFG_MODE, 10'(m));
    write_reg(sbpd_pkg::CFG_TRANS_ON, 10'(ton));
    write_reg(sbpd_pkg::CFG_TRANS_COL, 10'(tc));
    write_reg(sbpd_pkg::CFG_HEIGHT, h);
    write_reg(sbpd_pkg::CFG_COLOUR_BIT, 10'(cb));
    cfg_we_i <= 1'b0;
  endtask

  // Send a strip: colour byte, then n stream bytes; mostly zero-biased payload
  // so codes stay short, with full random bytes mixed in.
  task automatic send_strip(int n);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (n) send_byte($urandom_range(0, 3) == 0 ? 8'($urandom) :
                         8'($urandom & $urandom), 1'b0);
  endtask

  task automatic test_directed();
    setup(1'b0, 1'b1, 8'd0, 10'd4, 4'd8);
    send_byte(8'h00, 1'b0);          // colour byte taken without strip_start
    send_byte(8'h00, 1'b0);          // keep codes only
    send_byte(8'hFF, 1'b0);          // negate-and-add codes
    send_byte(8'h02, 1'b0);          // load colour
    send_byte(8'hFF, 1'b0);
    send_byte(8'h6B, 1'b0);          // add-step codes
    repeat (6) send_byte(8'h00, 1'b0); // run into strip end then ignored
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    setup(1'b1, 1'b1, 8'hFF, 10'd512, 4'd1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h13, 1'b0);          // 11 + delta 4: run follows
    send_byte(8'h00, 1'b0);          // run count 0 means 256
    send_byte(8'h1F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    setup(1'b1, 1'b0, 8'd5, 10'd1, 4'd0);
    send_byte(8'h10, 1'b1);
    send_byte(8'h13, 1'b0);
    send_byte(8'hFF, 1'b0);          // run clipped at strip end
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            8'($urandom_range(0, 255)),
            ph == 0 ? 10'd0 : ph == 1 ? 10'd1023 : 10'($urandom_range(1, 6)),
            ph == 2 ? 4'd15 : 4'($urandom_range(1, 8)));
      for (int s = 0; s < 3; s++) send_strip($urandom_range(4, 9));
    end
  endtask

  // Stall the receiver long enough that the block fills and stops taking items.
  task automatic test_backpressure();
    setup(1'b0, 1'b0, 8'd5, 10'd8, 4'd3);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_strip(8);
    join
  endtask

  // Receiver: own stall pattern, plus the forced hold-off.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (cycles % 64 < 32) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[30:0], m_axis_tlast};
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mode_q = 0; trans_on_q = 0; trans_col_q = 5; height_q = 480; cbits_q = 8;
    buf_q = 0; nbits_q = 0; colour_q = 0; step_neg_q = 1; col_q = 0; row_q = 0;
    phase_q = sbpd_pkg::PH_COLOUR; pend_q = 1; stage_q = sbpd_pkg::ST_START;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
